// ----- hw/rtl/dpbs_pkg.sv -----
package dpbs_pkg;

   // default width of the signed power
   localparam int DEF_EXPONENT_BITS = 32;

   // binary64 constants
   localparam logic [63:0] FP_ONE         = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;

   // floating-point unit operations
   localparam logic FPU_MUL   = 1'b0;
   localparam logic FPU_RECIP = 1'b1;

   // result source select
   localparam logic [1:0] OUT_BASE = 2'd0;
   localparam logic [1:0] OUT_ONE  = 2'd1;
   localparam logic [1:0] OUT_ACC  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       fpu_start;
      logic       fpu_op;
      logic       fpu_square;
      logic       wb_base;
      logic       wb_acc;
      logic       cnt_halve;
      logic       cnt_dec;
      logic       out_load;
      logic [1:0] out_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trivial;
      logic negative;
      logic cnt_zero;
      logic cnt_odd;
      logic fpu_done;
   } dp_status_type;

endpackage

// ----- hw/rtl/dpbs_fpu.sv -----
module dpbs_fpu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        op,
   input  logic [63:0] a_bits,
   input  logic [63:0] b_bits,
   output logic        done,
   output logic [63:0] result_bits
);
   import dpbs_pkg::*;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_MULT  = 3'd1;
   localparam logic [2:0] F_DNORM = 3'd2;
   localparam logic [2:0] F_DIV   = 3'd3;
   localparam logic [2:0] F_NORM  = 3'd4;
   localparam logic [2:0] F_RSH   = 3'd5;
   localparam logic [2:0] F_ROUND = 3'd6;
   localparam logic [2:0] F_DONE  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic               sign_ff, sign_in;
   logic signed [13:0] x_ff, x_in;
   logic [105:0]       p_ff, p_in;
   logic               sticky_ff, sticky_in;
   logic [52:0]        ma_ff, ma_in;
   logic [52:0]        mb_ff, mb_in;
   logic [53:0]        rem_ff, rem_in;
   logic [55:0]        q_ff, q_in;
   logic [5:0]         step_ff, step_in;
   logic [63:0]        res_ff, res_in;

   // operand decode
   logic [10:0] ea, eb, ea_eff, eb_eff;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;

   assign ea     = a_bits[62:52];
   assign eb     = b_bits[62:52];
   assign ea_eff = (ea == 11'd0) ? 11'd1 : ea;
   assign eb_eff = (eb == 11'd0) ? 11'd1 : eb;
   assign a_nan  = (ea == 11'h7FF) && (a_bits[51:0] != 52'd0);
   assign b_nan  = (eb == 11'h7FF) && (b_bits[51:0] != 52'd0);
   assign a_inf  = (ea == 11'h7FF) && (a_bits[51:0] == 52'd0);
   assign b_inf  = (eb == 11'h7FF) && (b_bits[51:0] == 52'd0);
   assign a_zero = (a_bits[62:0] == 63'd0);
   assign b_zero = (b_bits[62:0] == 63'd0);
   assign sx     = a_bits[63] ^ b_bits[63];

   // one 27x27 partial product per cycle
   logic [26:0]  op1, op2;
   logic [53:0]  pp;
   logic [105:0] pp_sh;

   assign op1 = step_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
   assign op2 = step_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];
   assign pp  = op1 * op2;

   always_comb begin
      case (step_ff[1:0])
         2'd0:    pp_sh = {52'd0, pp};
         2'd3:    pp_sh = {pp, 52'd0} << 2;
         default: pp_sh = {25'd0, pp, 27'd0};
      endcase
   end

   // restoring division step
   logic        div_bit;
   logic [53:0] rem_sub;

   assign div_bit = (rem_ff >= {1'b0, mb_ff});
   assign rem_sub = div_bit ? (rem_ff - {1'b0, mb_ff}) : rem_ff;

   // denormalizing right shift with sticky
   logic signed [13:0] rdiff;
   logic [6:0]         shamt;
   logic               lost;

   assign rdiff = 14'sd1 - x_ff;
   assign shamt = (rdiff > 14'sd127) ? 7'd127 : rdiff[6:0];
   assign lost  = |(p_ff & ~({106{1'b1}} << shamt));

   // round to nearest even and pack
   logic [52:0]        mant, mr;
   logic               gbit, sbit, up;
   logic [53:0]        msum;
   logic signed [13:0] xr;
   logic [63:0]        packed_res;

   always_comb begin
      mant = p_ff[105:53];
      gbit = p_ff[52];
      sbit = sticky_ff | (|p_ff[51:0]);
      up   = gbit & (sbit | mant[0]);
      msum = {1'b0, mant} + {53'd0, up};
      mr   = msum[53] ? msum[53:1] : msum[52:0];
      xr   = msum[53] ? (x_ff + 14'sd1) : x_ff;
      if (xr > 14'sd2046) begin
         packed_res = {sign_ff, 11'h7FF, 52'd0};
      end else begin
         packed_res = {sign_ff, (mr[52] ? xr[10:0] : 11'd0), mr[51:0]};
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sign_in   = sign_ff;
      x_in      = x_ff;
      p_in      = p_ff;
      sticky_in = sticky_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      res_in    = res_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in  = F_DONE;
               p_in      = 106'd0;
               sticky_in = 1'b0;
               step_in   = 6'd0;
               if (op == FPU_MUL) begin
                  if (a_nan) begin
                     res_in = a_bits | FP_QUIET_BIT;
                  end else if (b_nan) begin
                     res_in = b_bits | FP_QUIET_BIT;
                  end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                     res_in = FP_DEFAULT_NAN;
                  end else if (a_inf || b_inf) begin
                     res_in = {sx, 11'h7FF, 52'd0};
                  end else if (a_zero || b_zero) begin
                     res_in = {sx, 63'd0};
                  end else begin
                     sign_in  = sx;
                     ma_in    = {ea != 11'd0, a_bits[51:0]};
                     mb_in    = {eb != 11'd0, b_bits[51:0]};
                     x_in     = $signed({3'd0, ea_eff}) + $signed({3'd0, eb_eff})
                                - 14'sd1022;
                     state_in = F_MULT;
                  end
               end else begin
                  if (b_nan) begin
                     res_in = b_bits | FP_QUIET_BIT;
                  end else if (b_inf) begin
                     res_in = {b_bits[63], 63'd0};
                  end else if (b_zero) begin
                     res_in = {b_bits[63], 11'h7FF, 52'd0};
                  end else begin
                     sign_in  = b_bits[63];
                     mb_in    = {eb != 11'd0, b_bits[51:0]};
                     x_in     = 14'sd2046 - $signed({3'd0, eb_eff});
                     state_in = F_DNORM;
                  end
               end
            end
         end
         F_MULT: begin
            p_in    = p_ff + pp_sh;
            step_in = step_ff + 6'd1;
            if (step_ff[1:0] == 2'd3) begin
               state_in = F_NORM;
            end
         end
         F_DNORM: begin
            // bring a subnormal divisor to a leading one
            if (mb_ff[52]) begin
               rem_in   = {2'b01, 52'd0};
               q_in     = 56'd0;
               step_in  = 6'd0;
               state_in = F_DIV;
            end else begin
               mb_in = {mb_ff[51:0], 1'b0};
               x_in  = x_ff + 14'sd1;
            end
         end
         F_DIV: begin
            q_in    = {q_ff[54:0], div_bit};
            rem_in  = {rem_sub[52:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd55) begin
               p_in      = {q_ff[54:0], div_bit, 50'd0};
               sticky_in = (rem_sub != 54'd0);
               state_in  = F_NORM;
            end
         end
         F_NORM: begin
            if (!p_ff[105] && (x_ff > 14'sd1)) begin
               p_in = {p_ff[104:0], 1'b0};
               x_in = x_ff - 14'sd1;
            end else begin
               state_in = F_RSH;
            end
         end
         F_RSH: begin
            if (x_ff < 14'sd1) begin
               p_in      = p_ff >> shamt;
               sticky_in = sticky_ff | lost;
               x_in      = 14'sd1;
            end
            state_in = F_ROUND;
         end
         F_ROUND: begin
            res_in   = packed_res;
            state_in = F_DONE;
         end
         F_DONE: begin
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sign_ff   <= sign_in;
      x_ff      <= x_in;
      p_ff      <= p_in;
      sticky_ff <= sticky_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      step_ff   <= step_in;
      res_ff    <= res_in;
   end

   assign done        = (state_ff == F_DONE);
   assign result_bits = res_ff;

endmodule

// ----- hw/rtl/dpbs_datapath.sv -----
module dpbs_datapath #(
   parameter int EXPONENT_BITS = dpbs_pkg::DEF_EXPONENT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [63:0]                     req_base_bits,
   input  logic signed [EXPONENT_BITS-1:0] req_exponent,
   input  dpbs_pkg::dp_cmd_type            cmd,
   output dpbs_pkg::dp_status_type         status,
   output logic [63:0]                     rsp_result_bits
);
   import dpbs_pkg::*;

   logic [63:0]              base_ff, base_in;
   logic [63:0]              acc_ff, acc_in;
   logic [EXPONENT_BITS-1:0] count_ff, count_in;
   logic                     neg_ff, neg_in;
   logic [63:0]              out_ff, out_in;
   logic [63:0]              fpu_res;
   logic                     fpu_done;

   dpbs_fpu u_fpu (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.fpu_start),
      .op          (cmd.fpu_op),
      .a_bits      (cmd.fpu_square ? base_ff : acc_ff),
      .b_bits      (base_ff),
      .done        (fpu_done),
      .result_bits (fpu_res)
   );

   // working registers
   always_comb begin
      base_in  = base_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         base_in = req_base_bits;
         acc_in  = FP_ONE;
         neg_in  = req_exponent[EXPONENT_BITS-1];
         // magnitude; the most negative value maps to 2^(EXPONENT_BITS-1)
         count_in = req_exponent[EXPONENT_BITS-1] ? (~req_exponent + 1'b1)
                                                  : req_exponent;
      end
      if (cmd.wb_base) begin
         base_in = fpu_res;
      end
      if (cmd.wb_acc) begin
         acc_in = fpu_res;
      end
      if (cmd.cnt_halve) begin
         count_in = count_ff >> 1;
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_BASE: out_in = base_ff;
            OUT_ONE:  out_in = FP_ONE;
            default:  out_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else begin
         out_ff <= out_in;
      end
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
      neg_ff   <= neg_in;
   end

   // status back to the controller
   assign status.trivial  = (base_ff[62:0] == 63'd0) || (base_ff == FP_ONE);
   assign status.negative = neg_ff;
   assign status.cnt_zero = (count_ff == '0);
   assign status.cnt_odd  = count_ff[0];
   assign status.fpu_done = fpu_done;

   assign rsp_result_bits = out_ff;

endmodule

// ----- hw/rtl/dpbs_ctrl.sv -----
module dpbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  dpbs_pkg::dp_status_type status,
   output dpbs_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import dpbs_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_LOOP  = 3'd2;
   localparam logic [2:0] S_WSQ   = 3'd3;
   localparam logic [2:0] S_WMUL  = 3'd4;
   localparam logic [2:0] S_WREC  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.trivial) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_BASE;
               state_in     = S_DONE;
            end else if (status.cnt_zero) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ONE;
               state_in     = S_DONE;
            end else if (status.negative) begin
               cmd.fpu_start = 1'b1;
               cmd.fpu_op    = FPU_RECIP;
               state_in      = S_WREC;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (status.cnt_zero) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ACC;
               state_in     = S_DONE;
            end else if (status.cnt_odd) begin
               cmd.fpu_start = 1'b1;
               cmd.fpu_op    = FPU_MUL;
               state_in      = S_WMUL;
            end else begin
               cmd.fpu_start  = 1'b1;
               cmd.fpu_op     = FPU_MUL;
               cmd.fpu_square = 1'b1;
               state_in       = S_WSQ;
            end
         end
         S_WSQ: begin
            if (status.fpu_done) begin
               cmd.wb_base   = 1'b1;
               cmd.cnt_halve = 1'b1;
               state_in      = S_LOOP;
            end
         end
         S_WMUL: begin
            if (status.fpu_done) begin
               cmd.wb_acc  = 1'b1;
               cmd.cnt_dec = 1'b1;
               state_in    = S_LOOP;
            end
         end
         S_WREC: begin
            if (status.fpu_done) begin
               cmd.wb_base = 1'b1;
               state_in    = S_LOOP;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

// ----- hw/rtl/double_power_by_squaring.sv -----
// Raises a binary64 base to a signed integer power by repeated squaring, with
// every step rounded to nearest even (subnormals kept). Pulse start while busy
// is low to transfer a base and exponent; the result appears on
// rsp_result_bits for exactly one cycle with rsp_valid high and must be taken
// then, since the block cannot be held off. Zero and +1.0 bases come back
// unchanged, and for any other base an exponent of zero gives 1.0. Other
// items run one shared multiplier; each multiply for normal operands forms
// four 27x27 partial products, then normalizes and rounds. There is one
// multiply per set bit and one per further bit of the exponent magnitude,
// so at most about 2*EXPONENT_BITS multiplies; a negative exponent first
// needs a bit-serial reciprocal. Subnormal operands add a normalizing shift
// of one bit at a time. busy stays high until the result cycle ends.
module double_power_by_squaring #(
   parameter int EXPONENT_BITS = dpbs_pkg::DEF_EXPONENT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [63:0]                     req_base_bits,
   input  logic signed [EXPONENT_BITS-1:0] req_exponent,
   output logic                            rsp_valid,
   output logic [63:0]                     rsp_result_bits
);
   import dpbs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   dpbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dpbs_datapath #(
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_base_bits   (req_base_bits),
      .req_exponent    (req_exponent),
      .cmd             (cmd),
      .status          (status),
      .rsp_result_bits (rsp_result_bits)
   );

`ifndef NO_ASSERTIONS
   // a transfer in always leads to a busy block
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted but block not busy");

   // the result cycle ends the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block still busy after result");

   // the arithmetic unit only finishes work on a running item
   assert property (@(posedge clock) disable iff (reset)
      status.fpu_done |-> busy && !rsp_valid)
      else $error("arithmetic unit done outside an item");

   // a loaded result is presented in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result loaded but not presented");
`endif

endmodule
